>>> rtl/clkfr_pkg.sv
package clkfr_pkg;

    localparam int TAG_BITS     = 20;
    localparam int NUM_FRAMES_DEF = 64;
    localparam int POOL_BITS    = 7;
    localparam int FRAME_BITS   = 6;
    localparam int POOL_RESET   = 64;

    // file_mapped flag values
    localparam logic FILE_PAGE = 1'b1;
    localparam logic ANON_PAGE = 1'b0;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_REF   = 2'd2,
        KIND_PIN   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ACT_FREE_SLOT = 3'd0,
        ACT_CLEAN     = 3'd1,
        ACT_FILE_WB   = 3'd2,
        ACT_SWAP      = 3'd3,
        ACT_NO_VICTIM = 3'd4,
        ACT_FREED     = 3'd5,
        ACT_FREE_MISS = 3'd6,
        ACT_ACK       = 3'd7
    } t_action;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_FIND,
        S_SWEEP_START,
        S_SWEEP,
        S_LOOK,
        S_RMW,
        S_RESP
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_DISPATCH,
        OP_FIND,
        OP_SWEEP_START,
        OP_SWEEP,
        OP_LOOK,
        OP_RMW,
        OP_RESP
    } t_op;

    typedef struct packed {
        logic valid;
        logic accessed;
        logic dirty;
        logic pinned;
        logic writable;
        logic file_mapped;
        logic user;
        logic [TAG_BITS-1:0] tag;
    } t_slot;

    typedef struct packed {
        logic in_ready;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic req_fire;
        logic alloc;
        logic free;
        logic in_pool;
        logic fidx_ok;
        logic find_hit;
        logic look_hit;
        logic scan_last;
        logic sweep_end;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/clkfr_req_if.sv
interface clkfr_req_if import clkfr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [TAG_BITS-1:0] page_tag;
    logic [5:0]          frame_index;
    logic                is_writable;
    logic                is_file_mapped;
    logic                is_user_page;
    logic                write_access;
    logic                pin_value;

    modport source (
        output valid, kind, page_tag, frame_index, is_writable, is_file_mapped,
               is_user_page, write_access, pin_value,
        input  ready
    );
    modport sink (
        input  valid, kind, page_tag, frame_index, is_writable, is_file_mapped,
               is_user_page, write_access, pin_value,
        output ready
    );
endinterface

>>> rtl/clkfr_rsp_if.sv
interface clkfr_rsp_if import clkfr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [2:0]          action;
    logic [5:0]          granted_frame;
    logic [TAG_BITS-1:0] evicted_tag;

    modport source (
        output valid, action, granted_frame, evicted_tag,
        input  ready
    );
    modport sink (
        input  valid, action, granted_frame, evicted_tag,
        output ready
    );
endinterface

>>> rtl/clkfr_cfg_if.sv
interface clkfr_cfg_if import clkfr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [POOL_BITS-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

>>> rtl/clkfr_ram.sv
module clkfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/clkfr_ctrl.sv
module clkfr_ctrl import clkfr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.scan_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_stat.req_fire) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                priority if (i_stat.alloc && i_stat.in_pool) n_state = S_FIND;
                else if (i_stat.alloc)                       n_state = S_SWEEP;
                else if (i_stat.free)                        n_state = S_LOOK;
                else if (i_stat.fidx_ok)                     n_state = S_RMW;
                else                                         n_state = S_RESP;
            end
            S_FIND: begin
                priority if (i_stat.find_hit)  n_state = S_RESP;
                else if (i_stat.scan_last)     n_state = S_SWEEP_START;
                else                           n_state = S_FIND;
            end
            S_SWEEP_START: begin
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (i_stat.sweep_end) n_state = S_RESP;
            end
            S_LOOK: begin
                if (i_stat.look_hit || i_stat.scan_last) n_state = S_RESP;
            end
            S_RMW: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.in_ready = 1'b0;
        o_cmd.op       = OP_NONE;
        unique case (r_state)
            S_CLEAR:       o_cmd.op = OP_CLEAR;
            S_IDLE:        o_cmd.in_ready = 1'b1;
            S_DISPATCH:    o_cmd.op = OP_DISPATCH;
            S_FIND:        o_cmd.op = OP_FIND;
            S_SWEEP_START: o_cmd.op = OP_SWEEP_START;
            S_SWEEP:       o_cmd.op = OP_SWEEP;
            S_LOOK:        o_cmd.op = OP_LOOK;
            S_RMW:         o_cmd.op = OP_RMW;
            S_RESP:        o_cmd.op = OP_RESP;
            default:       o_cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> rtl/clkfr_dp.sv
module clkfr_dp import clkfr_pkg::*; #(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    output t_stat  o_stat,
    clkfr_req_if.sink   i_req,
    clkfr_rsp_if.source o_rsp,
    clkfr_cfg_if.sink   i_cfg
);

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int UW = $clog2(NUM_FRAMES + 1);
    localparam int MW = $clog2(2 * NUM_FRAMES + 1);
    localparam int CW = UW + POOL_BITS;
    localparam int XW = IW + FRAME_BITS;

    // configuration and table state
    logic [POOL_BITS-1:0]  r_pool;
    logic [IW-1:0]         r_hand, n_hand;
    logic [UW-1:0]         r_fiu, n_fiu;

    // latched request word
    t_kind                 r_kind;
    logic [TAG_BITS-1:0]   r_tag;
    logic [FRAME_BITS-1:0] r_fidx;
    logic                  r_wr, r_file, r_user, r_wacc, r_pin;

    // scan state
    logic [IW-1:0]         r_pos, n_pos;
    logic [MW-1:0]         r_moves, n_moves;
    logic                  r_user_req, n_user_req;

    // pending result and output register
    t_action               r_res_act, n_res_act;
    logic [IW-1:0]         r_res_frame, n_res_frame;
    logic [TAG_BITS-1:0]   r_res_tag, n_res_tag;
    logic                  r_out_valid, n_out_valid;
    t_action               r_out_act;
    logic [FRAME_BITS-1:0] r_out_frame;
    logic [TAG_BITS-1:0]   r_out_tag;

    // memory port
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr, ram_raddr;
    t_slot                 ram_wdata, ram_rdata;

    logic                  req_fire, out_free, out_load;
    logic [IW-1:0]         pos_inc, fidx_addr;
    logic                  scan_last, in_pool, fidx_ok;
    logic [CW-1:0]         pool_x, pool_eff;
    logic [XW-1:0]         fidx_x, frame_x;
    t_slot                 fill;
    logic                  check, cand, budget_out;
    logic                  find_hit, look_hit, sweep_end;
    t_action               vict_act;

    clkfr_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (NUM_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;
    assign req_fire    = i_req.valid && i_cmd.in_ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign out_load    = (i_cmd.op == OP_RESP) && out_free;

    assign scan_last = (r_pos == IW'(NUM_FRAMES - 1));
    assign pos_inc   = scan_last ? '0 : r_pos + 1'b1;

    // pool register clamped to 1..NUM_FRAMES
    always_comb begin
        pool_x = CW'(r_pool);
        priority if (pool_x == '0)                  pool_eff = CW'(1);
        else if (pool_x > CW'(NUM_FRAMES))          pool_eff = CW'(NUM_FRAMES);
        else                                        pool_eff = pool_x;
    end
    assign in_pool = CW'(r_fiu) < pool_eff;

    assign fidx_x    = XW'(r_fidx);
    assign fidx_ok   = fidx_x < XW'(NUM_FRAMES);
    assign fidx_addr = fidx_x[IW-1:0];

    always_comb begin
        fill             = '0;
        fill.valid       = 1'b1;
        fill.writable    = r_wr;
        fill.file_mapped = r_file;
        fill.user        = r_user;
        fill.tag         = r_tag;
    end

    // writeback action of a victim
    always_comb begin
        vict_act = ACT_CLEAN;
        if (ram_rdata.dirty && ram_rdata.writable) begin
            unique case (ram_rdata.file_mapped)
                FILE_PAGE: vict_act = ACT_FILE_WB;
                ANON_PAGE: vict_act = ACT_SWAP;
            endcase
        end
    end

    // second-chance step on the slot at r_pos
    assign check      = ram_rdata.valid && (!r_user_req || ram_rdata.user);
    assign cand       = check && !ram_rdata.accessed;
    assign budget_out = (r_moves == MW'(2 * NUM_FRAMES));

    assign find_hit  = !ram_rdata.valid;
    assign look_hit  = ram_rdata.valid && (ram_rdata.tag == r_tag);
    assign sweep_end = budget_out || (cand && !ram_rdata.pinned);

    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_pos;
        ram_wdata   = ram_rdata;
        ram_raddr   = pos_inc;
        n_pos       = r_pos;
        n_moves     = r_moves;
        n_user_req  = r_user_req;
        n_hand      = r_hand;
        n_fiu       = r_fiu;
        n_res_act   = r_res_act;
        n_res_frame = r_res_frame;
        n_res_tag   = r_res_tag;
        unique case (i_cmd.op)
            OP_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                n_pos     = pos_inc;
            end
            OP_DISPATCH: begin
                n_moves     = '0;
                n_user_req  = 1'b0;
                n_res_act   = ACT_ACK;
                n_res_frame = '0;
                n_res_tag   = '0;
                priority if ((r_kind == KIND_ALLOC && in_pool) || r_kind == KIND_FREE) begin
                    ram_raddr = '0;
                    n_pos     = '0;
                end else if (r_kind == KIND_ALLOC) begin
                    ram_raddr = r_hand;
                    n_pos     = r_hand;
                end else begin
                    ram_raddr = fidx_addr;
                    n_pos     = fidx_addr;
                end
            end
            OP_SWEEP_START: begin
                ram_raddr  = r_hand;
                n_pos      = r_hand;
                n_moves    = '0;
                n_user_req = 1'b0;
            end
            OP_FIND: begin
                if (find_hit) begin
                    ram_we      = 1'b1;
                    ram_wdata   = fill;
                    n_fiu       = r_fiu + 1'b1;
                    n_res_act   = ACT_FREE_SLOT;
                    n_res_frame = r_pos;
                end else begin
                    n_pos = pos_inc;
                end
            end
            OP_LOOK: begin
                priority if (look_hit) begin
                    ram_we             = 1'b1;
                    ram_wdata.valid    = 1'b0;
                    ram_wdata.accessed = 1'b0;
                    ram_wdata.dirty    = 1'b0;
                    ram_wdata.pinned   = 1'b0;
                    if (r_fiu != '0) n_fiu = r_fiu - 1'b1;
                    n_res_act   = ACT_FREED;
                    n_res_frame = r_pos;
                end else if (scan_last) begin
                    n_res_act = ACT_FREE_MISS;
                end else begin
                    n_pos = pos_inc;
                end
            end
            OP_RMW: begin
                if (ram_rdata.valid) begin
                    ram_we = 1'b1;
                    if (r_kind == KIND_REF) begin
                        ram_wdata.accessed = 1'b1;
                        if (r_wacc) ram_wdata.dirty = 1'b1;
                    end else begin
                        ram_wdata.pinned = r_pin;
                    end
                end
            end
            OP_SWEEP: begin
                if (check && ram_rdata.accessed) begin
                    ram_we             = 1'b1;
                    ram_wdata.accessed = 1'b0;
                    n_user_req         = 1'b1;
                end
                if (cand) n_user_req = 1'b0;
                if (budget_out) begin
                    n_hand      = r_pos;
                    n_res_act   = ACT_NO_VICTIM;
                    n_res_frame = '0;
                    n_res_tag   = '0;
                end else begin
                    n_moves = r_moves + 1'b1;
                    n_pos   = pos_inc;
                    if (cand && !ram_rdata.pinned) begin
                        ram_we      = 1'b1;
                        ram_wdata   = fill;
                        n_hand      = pos_inc;
                        n_res_act   = vict_act;
                        n_res_frame = r_pos;
                        n_res_tag   = ram_rdata.tag;
                    end
                end
            end
            OP_NONE, OP_RESP: begin
            end
            default: begin
            end
        endcase
    end

    assign n_out_valid = out_load ? 1'b1 : (o_rsp.ready ? 1'b0 : r_out_valid);
    assign frame_x     = XW'(r_res_frame);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool      <= POOL_BITS'(POOL_RESET);
            r_hand      <= '0;
            r_fiu       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) r_pool <= i_cfg.data;
            r_hand      <= n_hand;
            r_fiu       <= n_fiu;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_moves     <= n_moves;
        r_user_req  <= n_user_req;
        r_res_act   <= n_res_act;
        r_res_frame <= n_res_frame;
        r_res_tag   <= n_res_tag;
        if (req_fire) begin
            r_kind <= t_kind'(i_req.kind);
            r_tag  <= i_req.page_tag;
            r_fidx <= i_req.frame_index;
            r_wr   <= i_req.is_writable;
            r_file <= i_req.is_file_mapped;
            r_user <= i_req.is_user_page;
            r_wacc <= i_req.write_access;
            r_pin  <= i_req.pin_value;
        end
        if (out_load) begin
            r_out_act   <= r_res_act;
            r_out_frame <= frame_x[FRAME_BITS-1:0];
            r_out_tag   <= r_res_tag;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.action        = r_out_act;
    assign o_rsp.granted_frame = r_out_frame;
    assign o_rsp.evicted_tag   = r_out_tag;

    always_comb begin
        o_stat.req_fire  = req_fire;
        o_stat.alloc     = (r_kind == KIND_ALLOC);
        o_stat.free      = (r_kind == KIND_FREE);
        o_stat.in_pool   = in_pool;
        o_stat.fidx_ok   = fidx_ok;
        o_stat.find_hit  = find_hit;
        o_stat.look_hit  = look_hit;
        o_stat.scan_last = scan_last;
        o_stat.sweep_end = sweep_end;
        o_stat.out_free  = out_free;
    end

endmodule

>>> rtl/clock_frame_replacement.sv
// one request at a time; a word is accepted only in idle, after the previous result is staged
// allocate under the pool size: lowest free slot, scanned from slot 0, else an eviction sweep
// eviction: one slot per cycle through the slot memory read port, starting at the hand
// free by tag: scan from slot 0 for the valid slot with the tag; a miss after the last slot
// reference and pin: read-modify-write of the slot at frame_index, if that index is in range
// after reset a clearing pass over all slots empties the table; requests wait, config is taken
module clock_frame_replacement import clkfr_pkg::*; #(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    clkfr_req_if.sink   i_req,
    clkfr_rsp_if.source o_rsp,
    clkfr_cfg_if.sink   i_cfg
);

    t_cmd  w_cmd;
    t_stat w_stat;

    clkfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    clkfr_dp #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg)
    );

endmodule
